// ----- design/dbt_pkg.sv -----
// ----------------------------------------------------------------------------
// dbt_pkg
// Shared types and constants of the double-tap detector.
// ----------------------------------------------------------------------------
package dbt_pkg;

    localparam int REQ_W   = 2;
    localparam int DELTA_W = 20;
    localparam int WIN_W   = 21;
    localparam int CODE_W  = 3;
    localparam int TAPS_W  = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [WIN_W-1:0] WINDOW_RST = 21'd300000;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PRESS   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    // register index carried in paddr[2]
    localparam logic REG_WINDOW = 1'b0;

    localparam logic [TAPS_W-1:0] TAPS_NONE = 2'd0;
    localparam logic [TAPS_W-1:0] TAPS_ONE  = 2'd1;
    localparam logic [TAPS_W-1:0] TAPS_TWO  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_TRIG = 2'd2
    } t_phase;

    typedef enum logic [CODE_W-1:0] {
        RC_NONE      = 3'd0,
        RC_STARTED   = 3'd1,
        RC_ONGOING   = 3'd2,
        RC_TRIGGERED = 3'd3,
        RC_COMPLETED = 3'd4,
        RC_CANCELED  = 3'd5
    } t_code;

    typedef struct packed {
        t_code               code;
        logic [TAPS_W-1:0]   taps;
    } t_step_res;

endpackage

// ----- design/dbt_cfg.sv -----
// ----------------------------------------------------------------------------
// dbt_cfg
// APB register file holding the tap window.
// ----------------------------------------------------------------------------
module dbt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [dbt_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [dbt_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [dbt_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready,
    output logic [dbt_pkg::WIN_W-1:0]     o_window
);
    import dbt_pkg::*;

    logic [WIN_W-1:0] r_window;
    logic             w_wr;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
        end else if (w_wr) begin
            r_window <= i_pwdata[WIN_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == REG_WINDOW) begin
            o_prdata = {{(PDATA_W-WIN_W){1'b0}}, r_window};
        end
    end

    assign o_window = r_window;

endmodule

// ----- design/dbt_fsm.sv -----
// ----------------------------------------------------------------------------
// dbt_fsm
// Gesture phase, tap count and saturating time-since-last-tap counter.
// ----------------------------------------------------------------------------
module dbt_fsm #(
    parameter int TIME_WIDTH = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [dbt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [dbt_pkg::DELTA_W-1:0]   i_delta,
    input  logic [dbt_pkg::WIN_W-1:0]     i_window,
    output dbt_pkg::t_step_res            o_res
);
    import dbt_pkg::*;

    t_phase                r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_since, n_since;
    logic [TAPS_W-1:0]     r_taps,  n_taps;

    logic [TIME_WIDTH:0]   w_sum;
    logic [TIME_WIDTH-1:0] w_since_adv;
    logic [TIME_WIDTH-1:0] w_window;
    logic                  w_in_window;
    logic                  w_passed;

    assign w_window    = {{(TIME_WIDTH-WIN_W){1'b0}}, i_window};
    assign w_sum       = {1'b0, r_since} + {{(TIME_WIDTH+1-DELTA_W){1'b0}}, i_delta};
    // saturate on carry out
    assign w_since_adv = w_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : w_sum[TIME_WIDTH-1:0];
    assign w_in_window = (r_since <= w_window);
    assign w_passed    = (w_since_adv > w_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_since <= '0;
            r_taps  <= TAPS_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_since <= n_since;
            r_taps  <= n_taps;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_since = r_since;
        n_taps  = r_taps;
        unique case (i_req_type)
            REQ_PRESS: begin
                n_since = '0;
                if (r_phase == PH_WAIT && w_in_window) begin
                    n_phase = PH_TRIG;
                    n_taps  = TAPS_TWO;
                end else begin
                    n_phase = PH_WAIT;
                    n_taps  = TAPS_ONE;
                end
            end
            REQ_RELEASE: begin
                if (r_phase == PH_TRIG) begin
                    n_phase = PH_IDLE;
                    n_taps  = TAPS_NONE;
                end
            end
            REQ_TICK: begin
                n_since = w_since_adv;
                if (r_phase == PH_WAIT && w_passed) begin
                    n_phase = PH_IDLE;
                    n_taps  = TAPS_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    // result
    always_comb begin
        o_res.code = RC_NONE;
        o_res.taps = n_taps;
        unique case (i_req_type)
            REQ_PRESS: begin
                o_res.code = (r_phase == PH_WAIT && w_in_window) ? RC_TRIGGERED : RC_STARTED;
            end
            REQ_RELEASE: begin
                if (r_phase == PH_TRIG) begin
                    o_res.code = RC_COMPLETED;
                end
            end
            REQ_TICK: begin
                unique case (r_phase)
                    PH_WAIT: o_res.code = w_passed ? RC_CANCELED : RC_ONGOING;
                    PH_TRIG: o_res.code = RC_ONGOING;
                    default: o_res.code = RC_NONE;
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/double_tap_detector_core.sv -----
// ----------------------------------------------------------------------------
// double_tap_detector_core
// Double-tap gesture detector on a request stream with an APB window register.
// ----------------------------------------------------------------------------
// Each request (tick, press or release) produces exactly one result. A request
// taken sits in the input register, runs through the phase logic and is loaded
// into the result register once the result side is free; its result is then offered.
// A new request is taken every cycle while results are drained; the only limit
// is back-pressure on the result side. The window register (byte address 0,
// reset 300000 us) should be written while the stream is idle.
module double_tap_detector_core #(
    parameter int TIME_WIDTH = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dbt_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [19:0] delta_time
    input  logic [dbt_pkg::REQ_W-1:0]     i_s_axis_tuser,  // [1:0] req_type
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [dbt_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [2:0] result_code, [4:3] tap_count
    // configuration
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [dbt_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [dbt_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [dbt_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import dbt_pkg::*;

    logic               r_in_valid;
    logic [REQ_W-1:0]   r_in_type;
    logic [DELTA_W-1:0] r_in_delta;
    logic               r_out_valid;
    t_step_res          r_out;

    logic               w_adv;
    logic               w_step;
    logic               w_in_fire;
    logic [WIN_W-1:0]   w_window;
    t_step_res          w_res;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    dbt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_window  (w_window)
    );

    dbt_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_req_type (r_in_type),
        .i_delta    (r_in_delta),
        .i_window   (w_window),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_type  <= i_s_axis_tuser;
            r_in_delta <= i_s_axis_tdata[DELTA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-CODE_W-TAPS_W){1'b0}}, r_out.taps, r_out.code};

`ifndef SYNTHESIS
    // a trigger always leaves two taps counted
    a_trig_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_res.code == RC_TRIGGERED |-> w_res.taps == TAPS_TWO)
        else $error("trigger without two taps");

    // a cancel or completion always clears the count
    a_clear_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && (w_res.code == RC_CANCELED || w_res.code == RC_COMPLETED)
        |-> w_res.taps == TAPS_NONE)
        else $error("taps not cleared");

    // a stalled result is never dropped
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid)
        else $error("result dropped under stall");

    // a held request never sits while the result side can move
    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_s_axis_tready |-> w_step)
        else $error("request overwritten");
`endif

endmodule

// ----- tb/tb_double_tap_detector_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_tap_detector_core
// Self-checking bench for the double-tap detector: random request and result
// stalls, directed gesture corner cases, then random gestures under several
// window settings, every result checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_double_tap_detector_core;

    import dbt_pkg::*;

    localparam int TIME_W      = 22;
    localparam int ITEMS       = 700;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_WAIT  = 16;

    localparam logic [REQ_W-1:0]   REQ_UNUSED = 2'd3;
    localparam int unsigned        DELTA_MAX  = 20'hFFFFF;
    localparam int unsigned        WIN_MAX    = 21'h1FFFFF;

    // ------------------------------------------------------------------------
    // gesture predictor and queue of expected results
    // ------------------------------------------------------------------------
    class tap_checker;
        t_phase            phase;
        logic [TIME_W-1:0] elapsed_us;
        logic [TAPS_W-1:0] taps;
        logic [WIN_W-1:0]  window;
        t_step_res         expected_results[$];
        int                errors;

        function new();
            phase      = PH_IDLE;
            elapsed_us = '0;
            taps       = TAPS_NONE;
            window     = WINDOW_RST;
            errors     = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            // keep the log short on a badly broken block
            if (errors < 100)
                $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_request(logic [REQ_W-1:0] kind, logic [DELTA_W-1:0] delta);
            t_step_res         res;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] win_ext;
            win_ext  = {{(TIME_W-WIN_W){1'b0}}, window};
            res.code = RC_NONE;
            case (kind)
                REQ_PRESS: begin
                    if (phase == PH_WAIT && elapsed_us <= win_ext) begin
                        phase    = PH_TRIG;
                        taps     = TAPS_TWO;
                        res.code = RC_TRIGGERED;
                    end else begin
                        // late second press or press from idle / triggered
                        phase    = PH_WAIT;
                        taps     = TAPS_ONE;
                        res.code = RC_STARTED;
                    end
                    elapsed_us = '0;
                end
                REQ_RELEASE: begin
                    if (phase == PH_TRIG) begin
                        phase    = PH_IDLE;
                        taps     = TAPS_NONE;
                        res.code = RC_COMPLETED;
                    end
                end
                REQ_TICK: begin
                    sum        = {1'b0, elapsed_us} + {{(TIME_W+1-DELTA_W){1'b0}}, delta};
                    elapsed_us = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    if (phase == PH_WAIT) begin
                        if (elapsed_us > win_ext) begin
                            phase    = PH_IDLE;
                            taps     = TAPS_NONE;
                            res.code = RC_CANCELED;
                        end else begin
                            res.code = RC_ONGOING;
                        end
                    end else if (phase == PH_TRIG) begin
                        res.code = RC_ONGOING;
                    end
                end
                default: ;
            endcase
            res.taps = taps;
            expected_results.push_back(res);
        endfunction

        task check_result(logic [CODE_W-1:0] code, logic [TAPS_W-1:0] tap_cnt);
            t_step_res want;
            if (expected_results.size() == 0) begin
                report($sformatf("result code %0d taps %0d with no request pending",
                                 code, tap_cnt));
                return;
            end
            want = expected_results.pop_front();
            if (code !== want.code)
                report($sformatf("result code %0d, want %0d", code, want.code));
            if (tap_cnt !== want.taps)
                report($sformatf("tap count %0d, want %0d", tap_cnt, want.taps));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;   // [19:0] delta_time
    logic [REQ_W-1:0]     i_s_axis_tuser;   // [1:0] req_type
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;   // [2:0] result_code, [4:3] tap_count
    logic                 i_psel;
    logic                 i_penable;
    logic                 i_pwrite;
    logic [PADDR_W-1:0]   i_paddr;
    logic [PDATA_W-1:0]   i_pwdata;
    logic [PDATA_W-1:0]   o_prdata;
    logic                 o_pready;

    double_tap_detector_core #(
        .TIME_WIDTH(TIME_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    tap_checker  sb = new();
    int          cycles = 0;
    int          sent_items;
    int          send_pct;
    int          recv_pct;
    int unsigned window_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // both handshakes are sampled on pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_request(i_s_axis_tuser, i_s_axis_tdata[DELTA_W-1:0]);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata[CODE_W-1:0],
                            o_m_axis_tdata[CODE_W+TAPS_W-1:CODE_W]);
    end

    function automatic int unsigned draw_gap(int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 19) : 0;
    endfunction

    // result side: random stall before each result
    initial begin
        int unsigned gap;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(recv_pct);
            if (gap != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [DELTA_W-1:0] delta);
        int unsigned gap;
        gap = draw_gap(send_pct);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W-DELTA_W){1'b0}}, delta};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind != REQ_UNUSED)
            sent_items++;
    endtask

    // stop the stream and wait until every result is back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= {REG_WINDOW, 2'b00};
        i_pwdata  <= wdata;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic check_window();
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[WIN_W-1:0] !== sb.window)
            sb.report($sformatf("window reads %0d, want %0d", rd[WIN_W-1:0], sb.window));
    endtask

    task automatic set_window(input int unsigned value);
        logic [PDATA_W-1:0] wd;
        logic [PDATA_W-1:0] rd;
        // junk in the unused upper bits
        wd              = $urandom();
        wd[WIN_W-1:0]   = value[WIN_W-1:0];
        apb_access(1'b1, wd, rd);
        sb.window  = value[WIN_W-1:0];
        window_now = value;
        // let the bus go idle between the write and the read back
        @(posedge i_clk);
        check_window();
    endtask

    function automatic logic [DELTA_W-1:0] rand_delta();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return DELTA_W'($urandom_range(0, 1000));
            default: return DELTA_W'($urandom());
        endcase
    endfunction

    // advance time by total microseconds in ticks of at most DELTA_MAX each
    task automatic tick_span(input int unsigned total);
        int unsigned left;
        int unsigned piece;
        left = total;
        while (left != 0) begin
            piece = (left > DELTA_MAX) ? DELTA_MAX : left;
            if ($urandom_range(0, 2) == 0)
                piece = $urandom_range(1, piece);
            send_req(REQ_TICK, piece[DELTA_W-1:0]);
            left -= piece;
        end
    endtask

    // press, a gap at, inside or past the window edge, second press, hold, mostly a release
    task automatic gesture();
        int unsigned w;
        int unsigned span;
        w = window_now;
        send_req(REQ_PRESS, rand_delta());
        case ($urandom_range(0, 5))
            0:       span = w;
            1:       span = w + 1;
            2:       span = 0;
            3, 4:    span = $urandom_range(0, w);
            default: span = w + 1 + $urandom_range(0, w / 2 + 10);
        endcase
        tick_span(span);
        if ($urandom_range(0, 4) == 0)
            send_req(REQ_RELEASE, rand_delta());
        send_req(REQ_PRESS, rand_delta());
        repeat ($urandom_range(0, 3)) send_req(REQ_TICK, rand_delta());
        if ($urandom_range(0, 5) != 0)
            send_req(REQ_RELEASE, rand_delta());
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 25;
            default: return 100;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned win;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= REQ_TICK;
        i_psel          <= 1'b0;
        i_penable       <= 1'b0;
        i_pwrite        <= 1'b0;
        i_paddr         <= '0;
        i_pwdata        <= '0;
        send_pct        = 50;
        recv_pct        = 50;
        sent_items      = 0;
        window_now      = 32'(WINDOW_RST);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_window();

        // directed gestures at the reset window
        send_req(REQ_RELEASE, '0);
        send_req(REQ_TICK, '0);
        send_req(REQ_UNUSED, '1);
        send_req(REQ_PRESS, '1);
        send_req(REQ_TICK, DELTA_W'(WINDOW_RST));      // lands exactly on the window
        send_req(REQ_RELEASE, '0);
        send_req(REQ_UNUSED, '0);
        send_req(REQ_PRESS, '0);                       // triggers
        send_req(REQ_UNUSED, '1);
        send_req(REQ_TICK, '1);
        send_req(REQ_PRESS, '0);                       // press while triggered
        send_req(REQ_TICK, DELTA_W'(WINDOW_RST + 1));  // one past the window
        send_req(REQ_PRESS, '0);
        send_req(REQ_PRESS, '0);                       // zero gap
        send_req(REQ_RELEASE, '1);
        repeat (5) send_req(REQ_TICK, '1);      // drive the idle count to saturation
        send_req(REQ_PRESS, '0);
        send_req(REQ_TICK, 20'd100);
        drain_results();
        set_window(50);                          // shrink the window under a wait
        send_req(REQ_PRESS, '0);                 // late second press
        send_req(REQ_TICK, '0);
        send_req(REQ_TICK, 20'd51);

        sent_items = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       win = 0;
                1:       win = WIN_MAX;
                2:       win = 2000000;
                3:       win = $urandom_range(1, 2000);
                4:       win = DELTA_MAX;
                5:       win = DELTA_MAX + 1;
                6:       win = $urandom_range(0, WIN_MAX);
                default: win = WINDOW_RST;
            endcase
            // sometimes leave a wait open across the window change
            if ($urandom_range(0, 1) == 0) begin
                send_req(REQ_PRESS, rand_delta());
                send_req(REQ_TICK, DELTA_W'($urandom_range(0, (window_now > DELTA_MAX) ?
                                                           DELTA_MAX : window_now)));
            end
            drain_results();
            set_window(win);
            send_pct = (p == 0) ? 0 : pick_pct();
            recv_pct = (p == 0) ? 0 : pick_pct();
            while (sent_items < (p + 1) * ITEMS / PHASES) begin
                if ($urandom_range(0, 4) != 0)
                    gesture();
                else
                    send_req(REQ_W'($urandom_range(0, 3)), rand_delta());
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
